/* hdl/ps2kc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kc_pkg
// Shared types and command codes for the PS/2 keyboard controller core.
// ----------------------------------------------------------------------------
package ps2kc_pkg;

    // Default number of internal RAM words
    localparam int RAM_WORDS_DEF = 32;

    // Bus access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Port selector
    localparam logic PORT_DATA   = 1'b0;
    localparam logic PORT_STATUS = 1'b1;

    // Command groups, decoded from the top three bits
    localparam logic [2:0] GRP_RAM_READ  = 3'b001;  // 20..3F
    localparam logic [2:0] GRP_RAM_WRITE = 3'b011;  // 60..7F

    // Single commands
    localparam logic [7:0] CMD_TEST_PORT2 = 8'hA9;
    localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
    localparam logic [7:0] CMD_TEST_PORT1 = 8'hAB;
    localparam logic [7:0] CMD_READ_IN    = 8'hC0;
    localparam logic [7:0] CMD_READ_OUT   = 8'hD0;
    localparam logic [7:0] CMD_WRITE_OUT  = 8'hD1;
    localparam logic [7:0] CMD_WRITE_OB1  = 8'hD2;
    localparam logic [7:0] CMD_WRITE_OB2  = 8'hD3;
    localparam logic [7:0] CMD_WRITE_AUX  = 8'hD4;

    // Reply bytes
    localparam logic [7:0] REPLY_SELF_TEST = 8'h55;
    localparam logic [7:0] REPLY_TEST_OK   = 8'h00;
    localparam logic [7:0] REPLY_PORT_ALL  = 8'hFF;

    // One bus access
    typedef struct packed {
        logic [7:0] write_data;
        logic       port_select;
        logic       opcode;
    } ps2kc_item_t;

    // One access result
    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
    } ps2kc_result_t;

endpackage
`default_nettype wire

/* hdl/ps2kc_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kc_in_stage
// Input register: holds one bus access until the engine takes it.
// ----------------------------------------------------------------------------
module ps2kc_in_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire ps2kc_pkg::ps2kc_item_t s_item,
    input  wire logic                  take,
    output logic                       item_valid,
    output ps2kc_pkg::ps2kc_item_t     item
);
    import ps2kc_pkg::*;

    logic        valid_reg;
    ps2kc_item_t item_reg;

    // Free, or emptied this cycle by the engine
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/ps2kc_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kc_engine
// Controller state, internal RAM and single-pass access decode.
// ----------------------------------------------------------------------------
module ps2kc_engine #(
    parameter int RAM_WORDS = ps2kc_pkg::RAM_WORDS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   go,
    input  wire ps2kc_pkg::ps2kc_item_t item,
    output ps2kc_pkg::ps2kc_result_t    result
);
    import ps2kc_pkg::*;

    localparam int IDX_W = $clog2(RAM_WORDS);

    logic             obf_reg, obf_next;
    logic             ibf_reg, ibf_next;
    logic             cmd_reg, cmd_next;
    logic             await_reg, await_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [7:0]       last_cmd_reg, last_cmd_next;
    logic [7:0]       ram_reg [RAM_WORDS];
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_rdata;
    logic [7:0]       status;

    assign status    = {4'b0000, cmd_reg, 1'b0, ibf_reg, obf_reg};
    assign ram_rdata = ram_reg[item.write_data[IDX_W-1:0]];

    // Access decode and next state
    always_comb begin
        obf_next      = obf_reg;
        ibf_next      = ibf_reg;
        cmd_next      = cmd_reg;
        await_next    = await_reg;
        out_byte_next = out_byte_reg;
        last_cmd_next = last_cmd_reg;
        ram_we        = 1'b0;
        ram_waddr     = last_cmd_reg[IDX_W-1:0];
        result        = '0;
        if (item.opcode == OP_READ) begin
            if (item.port_select == PORT_STATUS) begin
                result.read_valid = 1'b1;
                result.read_data  = status;
            end else if (obf_reg) begin
                result.read_valid = 1'b1;
                result.read_data  = out_byte_reg;
                obf_next          = 1'b0;
            end
        end else if (item.port_select == PORT_STATUS) begin
            // Command write: new command drops any pending parameter
            cmd_next      = 1'b1;
            last_cmd_next = item.write_data;
            await_next    = 1'b0;
            if (item.write_data[7:5] == GRP_RAM_READ) begin
                out_byte_next = ram_rdata;
                obf_next      = 1'b1;
            end else if (item.write_data[7:5] == GRP_RAM_WRITE) begin
                await_next = 1'b1;
            end else begin
                unique case (item.write_data)
                    CMD_TEST_PORT2, CMD_TEST_PORT1: begin
                        out_byte_next = REPLY_TEST_OK;
                        obf_next      = 1'b1;
                    end
                    CMD_SELF_TEST: begin
                        out_byte_next = REPLY_SELF_TEST;
                        obf_next      = 1'b1;
                    end
                    CMD_READ_IN, CMD_READ_OUT: begin
                        out_byte_next = REPLY_PORT_ALL;
                        obf_next      = 1'b1;
                    end
                    CMD_WRITE_OUT, CMD_WRITE_OB1, CMD_WRITE_OB2, CMD_WRITE_AUX: begin
                        await_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (!ibf_reg) begin
            // Data write into a free input buffer
            if (await_reg) begin
                ram_we     = (last_cmd_reg[7:5] == GRP_RAM_WRITE);
                await_next = 1'b0;
            end else begin
                ibf_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obf_reg      <= 1'b0;
            ibf_reg      <= 1'b0;
            cmd_reg      <= 1'b0;
            await_reg    <= 1'b0;
            out_byte_reg <= '0;
            last_cmd_reg <= '0;
        end else if (go) begin
            obf_reg      <= obf_next;
            ibf_reg      <= ibf_next;
            cmd_reg      <= cmd_next;
            await_reg    <= await_next;
            out_byte_reg <= out_byte_next;
            last_cmd_reg <= last_cmd_next;
        end
    end

    // Internal RAM, zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RAM_WORDS; i++) begin
                ram_reg[i] <= '0;
            end
        end else if (go && ram_we) begin
            ram_reg[ram_waddr] <= item.write_data;
        end
    end

    // Checks
    a_await_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (last_cmd_reg[7:5] == GRP_RAM_WRITE) ||
                      (last_cmd_reg == CMD_WRITE_OUT) || (last_cmd_reg == CMD_WRITE_OB1) ||
                      (last_cmd_reg == CMD_WRITE_OB2) || (last_cmd_reg == CMD_WRITE_AUX))
        else $error("parameter pending without a parameter command");

    a_data_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        go && item.opcode == OP_READ && item.port_select == PORT_DATA
        |=> !obf_reg)
        else $error("data read left output-full set");

    a_self_test: assert property (@(posedge aclk) disable iff (!aresetn)
        go && item.opcode == OP_WRITE && item.port_select == PORT_STATUS &&
        item.write_data == CMD_SELF_TEST
        |=> obf_reg && out_byte_reg == REPLY_SELF_TEST && cmd_reg)
        else $error("self test reply missing");

    // A parameter only lands while the input buffer is free
    a_param_ibf: assert property (@(posedge aclk) disable iff (!aresetn)
        go && item.opcode == OP_WRITE && item.port_select == PORT_DATA && await_reg &&
        !ibf_reg
        |=> !await_reg && (ibf_reg == $past(ibf_reg)))
        else $error("parameter write mishandled");

endmodule
`default_nettype wire

/* hdl/ps2kc_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kc_out_stage
// Result register: holds one result until the master side takes it.
// ----------------------------------------------------------------------------
module ps2kc_out_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     load,
    input  wire ps2kc_pkg::ps2kc_result_t res_in,
    output logic                          can_load,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output ps2kc_pkg::ps2kc_result_t      m_res
);
    import ps2kc_pkg::*;

    logic          valid_reg;
    ps2kc_result_t res_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            res_reg <= res_in;
        end
    end

endmodule
`default_nettype wire

/* hdl/ps2_keyboard_controller_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_core
// Host side of a PS/2 controller: status/command and data port accesses.
// ----------------------------------------------------------------------------
// An accepted access waits in the input register; its result is registered
// in the result register behind m_tvalid. Throughput: one access per cycle
// unless m_tready stalls; state and RAM are updated in one decode pass.
// Reset (aresetn low, synchronous) clears status, output byte, pending
// command and all internal RAM words at once; no clearing pass is needed.
module ps2_keyboard_controller_core #(
    parameter int RAM_WORDS = ps2kc_pkg::RAM_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] write_data
    input  wire logic [1:0]  s_tuser,   // [0] opcode, [1] port_select
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] read_data
    output logic [0:0]       m_tuser    // [0] read_valid
);
    import ps2kc_pkg::*;

    ps2kc_item_t   s_item;
    ps2kc_item_t   item;
    ps2kc_result_t result;
    ps2kc_result_t m_res;
    logic          item_valid;
    logic          can_load;
    logic          go;

    assign s_item.opcode      = s_tuser[0];
    assign s_item.port_select = s_tuser[1];
    assign s_item.write_data  = s_tdata;

    assign go = item_valid && can_load;

    ps2kc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    ps2kc_engine #(
        .RAM_WORDS (RAM_WORDS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .item    (item),
        .result  (result)
    );

    ps2kc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_valid),
        .res_in   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata    = m_res.read_data;
    assign m_tuser[0] = m_res.read_valid;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 keyboard controller core. Host bus
// accesses go in as stream transactions and every reply is checked against
// a cycle-free model of the status, output buffer, pending command and RAM.
// ----------------------------------------------------------------------------
module tb_top;
    import ps2kc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;

    // Status byte bit positions
    localparam int ST_OBF_BIT = 0;
    localparam int ST_IBF_BIT = 1;
    localparam int ST_CMD_BIT = 3;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] write_data
    logic [1:0] s_tuser;    // [0] opcode, [1] port_select
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] read_data
    logic [0:0] m_tuser;    // [0] read_valid

    ps2_keyboard_controller_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Controller model state
    logic       kc_obf;
    logic       kc_ibf;
    logic       kc_cmd_flag;
    logic [7:0] kc_out_byte;
    logic [7:0] kc_in_byte;
    logic [7:0] kc_last_cmd;
    logic       kc_pending;
    logic [7:0] kc_ram [0:RAM_WORDS_DEF-1];

    ps2kc_result_t expected_replies[$];

    int  mismatch_count  = 0;
    int  access_count    = 0;
    int  reply_count     = 0;
    int  data_read_count = 0;
    int  idle_cycles     = 0;
    int  burst_left      = 0;
    bit  gaps_enabled    = 1'b1;
    bit  long_hold_req   = 1'b0;

    // Clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Model: apply one access, return the reply it produces
    function automatic ps2kc_result_t kc_predict_access(input logic op, input logic port,
                                                        input logic [7:0] wdata);
        ps2kc_result_t reply;
        reply = '0;
        if (op == OP_READ) begin
            if (port == PORT_STATUS) begin
                reply.read_valid = 1'b1;
                reply.read_data  = 8'h00;
                reply.read_data[ST_OBF_BIT] = kc_obf;
                reply.read_data[ST_IBF_BIT] = kc_ibf;
                reply.read_data[ST_CMD_BIT] = kc_cmd_flag;
            end else if (kc_obf) begin
                reply.read_valid = 1'b1;
                reply.read_data  = kc_out_byte;
                kc_obf = 1'b0;
            end
        end else if (port == PORT_STATUS) begin
            // New command: any pending parameter wait is dropped first
            kc_cmd_flag = 1'b1;
            kc_in_byte  = wdata;
            kc_last_cmd = wdata;
            kc_pending  = 1'b0;
            if (wdata[7:5] == GRP_RAM_READ) begin
                kc_out_byte = kc_ram[wdata[4:0]];
                kc_obf      = 1'b1;
            end else if (wdata[7:5] == GRP_RAM_WRITE) begin
                kc_pending = 1'b1;
            end else begin
                case (wdata)
                    CMD_TEST_PORT2, CMD_TEST_PORT1: begin
                        kc_out_byte = REPLY_TEST_OK;
                        kc_obf      = 1'b1;
                    end
                    CMD_SELF_TEST: begin
                        kc_out_byte = REPLY_SELF_TEST;
                        kc_obf      = 1'b1;
                    end
                    CMD_READ_IN, CMD_READ_OUT: begin
                        kc_out_byte = REPLY_PORT_ALL;
                        kc_obf      = 1'b1;
                    end
                    CMD_WRITE_OUT, CMD_WRITE_OB1, CMD_WRITE_OB2, CMD_WRITE_AUX: begin
                        kc_pending = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else if (!kc_ibf) begin
            // Data write; ignored while the input buffer is full
            kc_in_byte = wdata;
            kc_ibf     = 1'b1;
            if (kc_pending) begin
                if (kc_last_cmd[7:5] == GRP_RAM_WRITE)
                    kc_ram[kc_last_cmd[4:0]] = wdata;
                kc_pending = 1'b0;
                kc_ibf     = 1'b0;
            end
        end
        return reply;
    endfunction

    // Offer one access; bursts with random gaps in front of them
    task automatic send_access(input logic op, input logic port, input logic [7:0] wdata);
        ps2kc_result_t reply;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_enabled ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {port, op};
        s_tdata  <= wdata;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        reply = kc_predict_access(op, port, wdata);
        expected_replies.push_back(reply);
        access_count++;
    endtask

    // Status reads, empty data reads and the fixed-reply commands
    task automatic test_fixed_replies();
        send_access(OP_READ,  PORT_STATUS, 8'h00);
        send_access(OP_READ,  PORT_DATA,   8'hFF);
        send_access(OP_WRITE, PORT_STATUS, CMD_SELF_TEST);
        send_access(OP_READ,  PORT_DATA,   8'h00);
        send_access(OP_READ,  PORT_DATA,   8'h00);
        send_access(OP_WRITE, PORT_STATUS, CMD_TEST_PORT2);
        send_access(OP_READ,  PORT_STATUS, 8'h00);
        send_access(OP_READ,  PORT_DATA,   8'h00);
        send_access(OP_WRITE, PORT_STATUS, CMD_TEST_PORT1);
        send_access(OP_READ,  PORT_DATA,   8'h00);
        // Unread replies are overwritten by the next one
        send_access(OP_WRITE, PORT_STATUS, CMD_READ_IN);
        send_access(OP_WRITE, PORT_STATUS, CMD_READ_OUT);
        send_access(OP_READ,  PORT_DATA,   8'h00);
        send_access(OP_WRITE, PORT_STATUS, 8'h00);
        send_access(OP_WRITE, PORT_STATUS, 8'hFF);
        send_access(OP_READ,  PORT_STATUS, 8'h00);
    endtask

    // RAM writes through parameters and read-back, lowest and highest words
    task automatic test_ram_commands();
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, 5'd0});
        send_access(OP_WRITE, PORT_DATA,   8'hFF);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_READ, 5'd0});
        send_access(OP_READ,  PORT_DATA,   8'h00);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, 5'd31});
        send_access(OP_WRITE, PORT_DATA,   8'hA5);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_READ, 5'd31});
        send_access(OP_READ,  PORT_DATA,   8'h00);
    endtask

    // Output-port parameter commands and a command that drops a pending wait
    task automatic test_parameter_commands();
        send_access(OP_WRITE, PORT_STATUS, CMD_WRITE_OUT);
        send_access(OP_WRITE, PORT_DATA,   8'h5A);
        send_access(OP_WRITE, PORT_STATUS, CMD_WRITE_AUX);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, 5'd1});
        send_access(OP_WRITE, PORT_STATUS, CMD_SELF_TEST);
        send_access(OP_READ,  PORT_STATUS, 8'h00);
        send_access(OP_READ,  PORT_DATA,   8'h00);
    endtask

    // Well-formed traffic: data writes only ever carry a parameter
    task automatic test_random_traffic(input int n_items);
        int i;
        int pick;
        logic [7:0] b;
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            b = 8'($urandom);
            if (kc_pending && pick < 60) begin
                send_access(OP_WRITE, PORT_DATA, b);
            end else if (pick < 15) begin
                send_access(OP_READ, PORT_STATUS, b);
            end else if (pick < 40) begin
                send_access(OP_READ, PORT_DATA, b);
            end else begin
                case ($urandom_range(0, 5))
                    0: send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_READ, b[4:0]});
                    1: send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, b[4:0]});
                    2: send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, b[4:0]});
                    3: begin
                        case (b[2:0])
                            3'd0: send_access(OP_WRITE, PORT_STATUS, CMD_TEST_PORT2);
                            3'd1: send_access(OP_WRITE, PORT_STATUS, CMD_SELF_TEST);
                            3'd2: send_access(OP_WRITE, PORT_STATUS, CMD_TEST_PORT1);
                            3'd3: send_access(OP_WRITE, PORT_STATUS, CMD_READ_IN);
                            default: send_access(OP_WRITE, PORT_STATUS, CMD_READ_OUT);
                        endcase
                    end
                    4: send_access(OP_WRITE, PORT_STATUS, CMD_WRITE_OUT + 8'(b[1:0]));
                    default: send_access(OP_WRITE, PORT_STATUS, b);
                endcase
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        gaps_enabled  = 1'b0;
        test_random_traffic(120);
        gaps_enabled  = 1'b1;
    endtask

    // A plain data byte leaves the input buffer full for good; run last
    task automatic test_stuck_input();
        int i;
        send_access(OP_WRITE, PORT_DATA,   8'h3C);
        send_access(OP_READ,  PORT_STATUS, 8'h00);
        send_access(OP_WRITE, PORT_DATA,   8'hC3);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_WRITE, 5'd2});
        send_access(OP_WRITE, PORT_DATA,   8'h77);
        send_access(OP_WRITE, PORT_STATUS, {GRP_RAM_READ, 5'd2});
        send_access(OP_READ,  PORT_DATA,   8'h00);
        for (i = 0; i < 180; i++)
            send_access(1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Receiver stall pattern, plus the long hold on request
    initial begin : receiver_pattern
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (seg_left % 4 != 0);
                endcase
            end
        end
    end

    // Reply checker
    always @(posedge aclk) begin
        ps2kc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected reply valid=%0b data=%02h",
                             m_tuser[0], m_tdata);
            end else begin
                want = expected_replies.pop_front();
                if (want.read_valid)
                    data_read_count++;
                if (m_tuser[0] !== want.read_valid || m_tdata !== want.read_data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: reply %0d expected valid=%0b data=%02h, got valid=%0b data=%02h",
                                 reply_count, want.read_valid, want.read_data,
                                 m_tuser[0], m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        kc_obf      = 1'b0;
        kc_ibf      = 1'b0;
        kc_cmd_flag = 1'b0;
        kc_out_byte = 8'h00;
        kc_in_byte  = 8'h00;
        kc_last_cmd = 8'h00;
        kc_pending  = 1'b0;
        for (int i = 0; i < RAM_WORDS_DEF; i++)
            kc_ram[i] = 8'h00;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 2'b00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_fixed_replies();
        test_ram_commands();
        test_parameter_commands();
        test_random_traffic(1500);
        test_backpressure();
        test_stuck_input();

        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d host accesses across status, data, command and parameter traffic;",
                 access_count);
        $display("%0d replies compared, %0d of them carrying a byte.",
                 reply_count, data_read_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
